// ----- hw/rtl/sstr_pkg.sv -----
// Shared types, codes and helpers for the substring search block.
// No dependencies; imported by sstr_cell, substring_search and the testbench.
package sstr_pkg;

	localparam int MATCH_POS_W = 32;

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_NEEDLE = 2'd1;
	localparam logic [1:0] REQ_HAY    = 2'd2;
	localparam logic [1:0] REQ_END    = 2'd3;

	localparam logic [1:0] ST_NONE     = 2'd0;
	localparam logic [1:0] ST_MATCH    = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [MATCH_POS_W-1:0] match_position;
	} rsp_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic       clear;
		logic       step;
		logic       fold;
		logic [7:0] load_byte;
		logic [7:0] hay_byte;
	} cell_ctl_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
		logic [7:0] r;
		r = b;
		if (en && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
			r = b + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/sstr_cell.sv -----
// One cell of the shift-and chain: one needle byte and one prefix-match bit.
// Depends on sstr_pkg.
module sstr_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sstr_pkg::cell_ctl_t ctl,
	input  logic                load_en,
	input  logic                prev,
	output logic                hit,
	output logic                partial
);
	import sstr_pkg::*;

	logic [7:0] needle_q;
	logic       partial_q;

	always_ff @(posedge clk) begin
		if (load_en) begin
			needle_q <= ctl.load_byte;
		end
	end

	// prefix ends here: byte matches, shorter prefix matched one byte earlier
	assign hit = prev && (fold_byte(needle_q, ctl.fold) == ctl.hay_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= 1'b0;
		end else if (ctl.clear) begin
			partial_q <= 1'b0;
		end else if (ctl.step) begin
			partial_q <= hit;
		end
	end

	assign partial = partial_q;

endmodule

// ----- hw/rtl/substring_search.sv -----
// Streaming first-occurrence substring search over a chain of needle cells.
// A result is registered in the output register, or in the skid entry while the output register is held.
// Throughput: one beat per cycle while req is not stalled; the broadcast compare across all cells sets it.
// req stalls only while both the output register and the skid entry hold results.
// Reset clears the search state and fold_case; needle bytes are unset until loaded.
module substring_search #(
	parameter int NEEDLE_MAX    = 32,
	parameter int POSITION_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic           cfg_wr_data,
	input  logic           req_valid,
	output logic           req_stall,
	input  sstr_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sstr_pkg::rsp_t rsp
);
	import sstr_pkg::*;

	localparam int CNT_W = $clog2(NEEDLE_MAX + 1);
	localparam int EXT_W = (POSITION_BITS > MATCH_POS_W) ? POSITION_BITS : MATCH_POS_W;

	logic                     fold_q;
	logic [CNT_W-1:0]         count_q;
	logic [POSITION_BITS-1:0] hay_idx_q;
	logic                     done_q;
	logic                     ovf_q;
	logic                     hay_seen_q;

	logic      out_valid_q;
	rsp_t      out_q;
	logic      skid_valid_q;
	rsp_t      skid_q;

	logic      accept;
	logic      active;
	logic      is_needle;
	logic      is_hay;
	logic      is_end;
	logic      needle_full;
	logic      res_fire;
	rsp_t      res;
	logic      match;
	logic      out_take;
	cell_ctl_t ctl;

	logic [NEEDLE_MAX-1:0] hit;
	logic [NEEDLE_MAX-1:0] partial;
	logic [NEEDLE_MAX-1:0] last_hit;
	logic [NEEDLE_MAX-1:0] load_en;

	logic [POSITION_BITS-1:0] start_pos;
	logic [EXT_W-1:0]         start_ext;

	assign accept      = req_valid && !req_stall;
	assign active      = accept && !done_q;
	assign is_needle   = active && req.req_type == REQ_NEEDLE && !hay_seen_q;
	assign is_hay      = active && req.req_type == REQ_HAY;
	assign is_end      = active && req.req_type == REQ_END;
	assign needle_full = count_q == CNT_W'(NEEDLE_MAX);

	always_comb begin
		ctl.clear     = accept && req.req_type == REQ_CLEAR;
		ctl.step      = is_hay && !ovf_q;
		ctl.fold      = fold_q;
		ctl.load_byte = req.data_byte;
		ctl.hay_byte  = fold_byte(req.data_byte, fold_q);
	end

	genvar i;
	generate
		for (i = 0; i < NEEDLE_MAX; i++) begin : g_cell
			logic prev;
			if (i == 0) begin : g_head
				assign prev = 1'b1;
			end else begin : g_link
				assign prev = partial[i-1];
			end
			assign load_en[i]  = is_needle && !needle_full && count_q == CNT_W'(i);
			assign last_hit[i] = hit[i] && count_q == CNT_W'(i + 1);
			sstr_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.load_en (load_en[i]),
				.prev    (prev),
				.hit     (hit[i]),
				.partial (partial[i])
			);
		end
	endgenerate

	assign match     = |last_hit;
	assign start_pos = hay_idx_q - POSITION_BITS'(count_q) + POSITION_BITS'(1);
	assign start_ext = EXT_W'(start_pos);

	always_comb begin
		res_fire           = 1'b0;
		res.status         = ST_NONE;
		res.match_position = '0;
		if (is_hay && !ovf_q) begin
			if (count_q == '0) begin
				res_fire   = 1'b1;
				res.status = ST_MATCH;
			end else if (match) begin
				res_fire           = 1'b1;
				res.status         = ST_MATCH;
				res.match_position = start_ext[MATCH_POS_W-1:0];
			end
		end else if (is_end) begin
			res_fire = 1'b1;
			if (ovf_q) begin
				res.status = ST_OVERFLOW;
			end else if (count_q == '0) begin
				res.status = ST_MATCH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_q <= 1'b0;
		end else if (cfg_wr_en) begin
			fold_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			hay_idx_q  <= '0;
			done_q     <= 1'b0;
			ovf_q      <= 1'b0;
			hay_seen_q <= 1'b0;
		end else if (ctl.clear) begin
			count_q    <= '0;
			hay_idx_q  <= '0;
			done_q     <= 1'b0;
			ovf_q      <= 1'b0;
			hay_seen_q <= 1'b0;
		end else begin
			if (is_needle) begin
				if (needle_full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (is_hay) begin
				hay_seen_q <= 1'b1;
				hay_idx_q  <= hay_idx_q + POSITION_BITS'(1);
			end
			if (res_fire) begin
				done_q <= 1'b1;
			end
		end
	end

	// output register with one skid entry
	assign out_take  = out_valid_q && !rsp_stall;
	assign req_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_fire) begin
			if (!out_valid_q || out_take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (res_fire) begin
			if (!out_valid_q || out_take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without output beat");

	a_ovf_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> needle_full)
		else $error("needle overflow flagged below capacity");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ST_MATCH) |-> rsp.match_position == '0)
		else $error("nonzero position without match");

	a_done_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_fire && !ctl.clear) |=> done_q)
		else $error("search not closed after result");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for substring_search: a queue-fed driver, a monitor with a
// shift-and search predictor, randomized idling and stalls, and both fold_case settings.
// Depends on sstr_pkg (beat types, request and status codes) and the substring_search RTL.
module testbench;
	import sstr_pkg::*;

	localparam int NMAX        = 32;
	localparam int POS_W       = 32;
	localparam int HOLD_CYCLES = 300;

	logic clk         = 1'b0;
	logic arst_n      = 1'b0;
	logic cfg_wr_en   = 1'b0;
	logic cfg_wr_data = 1'b0;
	logic req_valid   = 1'b0;
	logic req_stall;
	req_t req         = '0;
	logic rsp_valid;
	logic rsp_stall   = 1'b0;
	rsp_t rsp;

	substring_search #(
		.NEEDLE_MAX(NMAX),
		.POSITION_BITS(POS_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #2 clk = ~clk;

	req_t beat_q [$];
	rsp_t search_results_q [$];
	logic req_taken = 1'b0;
	int   send_idle_pct  = 20;
	int   recv_stall_pct = 86;
	int   hold_req = 0;
	int   hold_seen = 0;
	int   hold_left = 0;
	int   bad_count = 0;
	int   beats_queued = 0;
	int   searches = 0;
	int   n_match = 0;
	int   n_none = 0;
	int   n_over = 0;

	// search predictor state
	logic             fold_on = 1'b0;
	logic [7:0]       nd_bytes [NMAX];
	int               nd_len = 0;
	logic [NMAX-1:0]  prefix_hits = '0;
	logic [POS_W-1:0] hay_pos = '0;
	logic             srch_done = 1'b0;
	logic             nd_over = 1'b0;
	logic             hay_started = 1'b0;

	function automatic logic [7:0] to_lower(input logic [7:0] b, input logic on);
		return (on && b inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) ? (b | 8'h20) : b;
	endfunction

	task automatic expect_result(input logic [1:0] st, input logic [POS_W-1:0] pos);
		rsp_t r;
		r.status = st;
		r.match_position = pos;
		search_results_q.push_back(r);
	endtask

	task automatic search_step(input req_t r);
		logic [7:0]      hb;
		logic [NMAX-1:0] nxt;
		int              i;
		if (r.req_type == REQ_CLEAR) begin
			nd_len = 0;
			prefix_hits = '0;
			hay_pos = '0;
			srch_done = 1'b0;
			nd_over = 1'b0;
			hay_started = 1'b0;
		end else if (!srch_done) begin
			case (r.req_type)
				REQ_NEEDLE: begin
					if (!hay_started) begin
						if (nd_len >= NMAX) begin
							nd_over = 1'b1;
						end else begin
							nd_bytes[nd_len] = r.data_byte;
							nd_len++;
						end
					end
				end
				REQ_HAY: begin
					hay_started = 1'b1;
					if (!nd_over) begin
						if (nd_len == 0) begin
							srch_done = 1'b1;
							expect_result(ST_MATCH, '0);
						end else begin
							hb = to_lower(r.data_byte, fold_on);
							nxt = '0;
							for (i = 0; i < nd_len; i++) begin
								if (to_lower(nd_bytes[i], fold_on) == hb &&
										(i == 0 || prefix_hits[i-1])) begin
									nxt[i] = 1'b1;
								end
							end
							prefix_hits = nxt;
							if (prefix_hits[nd_len-1]) begin
								srch_done = 1'b1;
								expect_result(ST_MATCH, hay_pos - POS_W'(nd_len - 1));
							end
						end
					end
					hay_pos = hay_pos + 1'b1;
				end
				default: begin
					srch_done = 1'b1;
					if (nd_over) begin
						expect_result(ST_OVERFLOW, '0);
					end else if (nd_len == 0) begin
						expect_result(ST_MATCH, '0);
					end else begin
						expect_result(ST_NONE, '0);
					end
				end
			endcase
		end
	endtask

	task automatic check_result(input rsp_t got);
		rsp_t want;
		if (search_results_q.size() == 0) begin
			bad_count++;
			if (bad_count <= 10) begin
				$display("unexpected result: status %0d position %0d",
					got.status, got.match_position);
			end
		end else begin
			want = search_results_q.pop_front();
			if (got.status !== want.status || got.match_position !== want.match_position) begin
				bad_count++;
				if (bad_count <= 10) begin
					$display("mismatch: expected status %0d position %0d, got status %0d position %0d",
						want.status, want.match_position, got.status, got.match_position);
				end
			end
			case (got.status)
				ST_MATCH: n_match++;
				ST_OVERFLOW: n_over++;
				default: n_none++;
			endcase
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= req_valid && !req_stall;
			if (cfg_wr_en) begin
				fold_on = cfg_wr_data;
			end
			if (rsp_valid && !rsp_stall) begin
				check_result(rsp);
			end
			if (req_valid && !req_stall) begin
				search_step(req);
			end
		end
	end

	// driver: a beat holds until taken
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (beat_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				req <= beat_q.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic push_beat(input logic [1:0] t, input logic [7:0] b);
		req_t x;
		x.req_type = t;
		x.data_byte = b;
		beat_q.push_back(x);
		beats_queued++;
		if (t == REQ_CLEAR) begin
			searches++;
		end
	endtask

	function automatic logic [7:0] pick_byte(input bit wide);
		logic [7:0] b;
		if (wide) begin
			b = 8'($urandom_range(255));
		end else begin
			b = CHAR_UPPER_A + 8'($urandom_range(1));
			if ($urandom_range(1)) begin
				b = b + CASE_OFFSET;
			end
		end
		return b;
	endfunction

	task automatic add_search();
		logic [7:0] nd [$];
		logic [7:0] b;
		int         nlen;
		int         hlen;
		int         at;
		int         r;
		int         i;
		bit         wide;
		bit         plant;
		r = $urandom_range(99);
		if (r < 8) begin
			nlen = 0;
		end else if (r < 80) begin
			nlen = $urandom_range(5, 1);
		end else if (r < 92) begin
			nlen = $urandom_range(NMAX, 6);
		end else begin
			nlen = $urandom_range(NMAX + 4, NMAX + 1);
		end
		hlen = $urandom_range(30);
		wide = ($urandom_range(4) == 0);
		push_beat(REQ_CLEAR, 8'($urandom_range(255)));
		for (i = 0; i < nlen; i++) begin
			nd.push_back(pick_byte(wide));
			push_beat(REQ_NEEDLE, nd[i]);
		end
		plant = (hlen >= nlen) && ($urandom_range(2) != 0);
		at = plant ? $urandom_range(hlen - nlen) : 0;
		for (i = 0; i < hlen; i++) begin
			if (plant && i >= at && i < at + nlen) begin
				b = nd[i-at];
				if ($urandom_range(3) == 0 && to_lower(b, 1'b1) != b) begin
					b = b ^ CASE_OFFSET;
				end
			end else begin
				b = pick_byte(wide);
			end
			push_beat(REQ_HAY, b);
			if ($urandom_range(24) == 0) begin
				push_beat(REQ_NEEDLE, pick_byte(wide));
			end
		end
		if ($urandom_range(7) != 0) begin
			push_beat(REQ_END, 8'($urandom_range(255)));
		end
		if ($urandom_range(5) == 0) begin
			for (i = 0; i < $urandom_range(3, 1); i++) begin
				push_beat(2'($urandom_range(3, 1)), 8'($urandom_range(255)));
			end
		end
	endtask

	task automatic add_noise();
		int i;
		for (i = 0; i < $urandom_range(4, 1); i++) begin
			push_beat(2'($urandom_range(3)), 8'($urandom_range(255)));
		end
	endtask

	task automatic drain();
		while (beat_q.size() != 0 || req_valid || search_results_q.size() != 0) begin
			@(posedge clk);
			#1;
		end
		repeat (4) @(posedge clk);
		#1;
	endtask

	task automatic write_fold(input logic v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		#1;
	endtask

	initial begin
		#2000000;
		$display("[substring_search] ERROR");
		$finish;
	end

	initial begin
		int ph;
		int i;
		int target;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		#1;

		// empty needle straight out of reset, then an ignored beat after done
		push_beat(REQ_END, 8'h00);
		push_beat(REQ_HAY, 8'hFF);
		// needle with zero and all-ones bytes
		push_beat(REQ_CLEAR, 8'hFF);
		push_beat(REQ_NEEDLE, 8'h00);
		push_beat(REQ_NEEDLE, 8'hFF);
		push_beat(REQ_HAY, 8'hFF);
		push_beat(REQ_HAY, 8'h00);
		push_beat(REQ_HAY, 8'hFF);
		// empty needle hit on the first haystack beat
		push_beat(REQ_CLEAR, 8'h00);
		push_beat(REQ_HAY, 8'h78);
		// case kept, late needle beat ignored, no match at end
		push_beat(REQ_CLEAR, 8'h00);
		push_beat(REQ_NEEDLE, 8'h61);
		push_beat(REQ_HAY, 8'h41);
		push_beat(REQ_NEEDLE, 8'h41);
		push_beat(REQ_HAY, 8'h41);
		push_beat(REQ_END, 8'hFF);
		push_beat(REQ_END, 8'h00);
		drain();

		write_fold(1'b1);
		push_beat(REQ_CLEAR, 8'h00);
		push_beat(REQ_NEEDLE, CHAR_UPPER_Z);
		push_beat(REQ_NEEDLE, 8'h40);
		push_beat(REQ_HAY, 8'h7A);
		push_beat(REQ_HAY, 8'h40);
		push_beat(REQ_CLEAR, 8'h00);
		push_beat(REQ_NEEDLE, 8'h5B);
		push_beat(REQ_HAY, 8'h7B);
		push_beat(REQ_END, 8'h00);
		drain();

		for (ph = 0; ph < 9; ph++) begin
			write_fold(ph[0]);
			if (ph < 3) begin
				send_idle_pct = 20;
				recv_stall_pct = 86;
			end else if (ph < 6) begin
				send_idle_pct = 86;
				recv_stall_pct = 20;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			target = beats_queued + 130;
			while (beats_queued < target) begin
				if ($urandom_range(9) == 0) begin
					add_noise();
				end else begin
					add_search();
				end
			end
			drain();
		end

		// long receiver hold-off with a result-heavy beat stream
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req++;
		for (i = 0; i < 50; i++) begin
			push_beat(REQ_CLEAR, 8'($urandom_range(255)));
			push_beat(REQ_HAY, 8'($urandom_range(255)));
		end
		drain();

		$display("%0d beats over %0d searches, both fold_case values, idle and hold-off phases",
			beats_queued, searches);
		$display("results: %0d match, %0d no match, %0d overflow", n_match, n_none, n_over);
		if (bad_count == 0 && search_results_q.size() == 0) begin
			$display("[substring_search] OK");
		end else begin
			$display("[substring_search] ERROR");
		end
		$finish;
	end

endmodule
